>>> rtl/ssid_pkg.sv
// Package for the sorted set insert/delete unit.
// Holds the operation, status and state codes and the cell control types.
// No dependencies.
package ssid_pkg;

    localparam int IN_VALUE_W  = 32;
    localparam int OUT_COUNT_W = 5;
    localparam int STATUS_W    = 3;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_DELETE = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 3'd0,
        ST_PRESENT  = 3'd1,
        ST_DELETED  = 3'd2,
        ST_ABSENT   = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    typedef enum logic {
        S_IDLE  = 1'b0,
        S_APPLY = 1'b1
    } state_t;

    typedef struct packed {
        logic ins;
        logic del;
    } cell_ctrl_t;

    typedef struct packed {
        logic ge;
        logic eq;
    } cell_flags_t;

endpackage

>>> rtl/ssid_in_if.sv
// Request channel: operation and value, valid/ready handshake.
// Depends on ssid_pkg.
interface ssid_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 operation;
    logic signed [ssid_pkg::IN_VALUE_W-1:0] value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

>>> rtl/ssid_out_if.sv
// Response channel: status and count, valid/ready handshake.
// Depends on ssid_pkg.
interface ssid_out_if;
    logic                                valid;
    logic                                ready;
    logic [ssid_pkg::STATUS_W-1:0]       status;
    logic [ssid_pkg::OUT_COUNT_W-1:0]    count;

    modport source (output valid, output status, output count, input ready);
    modport sink   (input valid, input status, input count, output ready);
endinterface

>>> rtl/ssid_cell.sv
// One storage cell of the sorted chain: holds one entry and its compare flags.
// Shifts from the left neighbor on insert, from the right on delete. Uses ssid_pkg.
module ssid_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int CNT_W      = 5,
    parameter int INDEX      = 0
) (
    input  logic                         clk,
    input  logic                         cmp_en,
    input  logic signed [DATA_WIDTH-1:0] cmp_value,
    input  logic signed [DATA_WIDTH-1:0] upd_value,
    input  logic [CNT_W-1:0]             count,
    input  ssid_pkg::cell_ctrl_t         ctrl,
    input  logic signed [DATA_WIDTH-1:0] left_entry,
    input  logic                         left_ge,
    input  logic signed [DATA_WIDTH-1:0] right_entry,
    output logic signed [DATA_WIDTH-1:0] entry,
    output ssid_pkg::cell_flags_t        flags
);
    import ssid_pkg::*;

    logic signed [DATA_WIDTH-1:0] entry_reg;
    logic signed [DATA_WIDTH-1:0] entry_next;
    logic                         ge_reg;
    logic                         eq_reg;
    logic                         occupied;

    // empty slots compare as greater than any value
    assign occupied = (count > CNT_W'(INDEX));

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.ins && ge_reg)
        begin
            entry_next = left_ge ? left_entry : upd_value;
        end
        else if (ctrl.del && (ge_reg || eq_reg))
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        if (cmp_en)
        begin
            ge_reg <= !occupied || (entry_reg > cmp_value);
            eq_reg <= occupied && (entry_reg == cmp_value);
        end
    end

    assign entry    = entry_reg;
    assign flags.ge = ge_reg;
    assign flags.eq = eq_reg;

endmodule

>>> rtl/sorted_set_insert_delete_unit.sv
// Top level of the sorted set insert/delete unit: control FSM, fill count,
// result register and the chain of ssid_cell. Uses ssid_pkg, ssid_in_if, ssid_out_if.
//
//   port   dir   fields               per transfer
//   req    in    operation, value     one insert or delete
//   rsp    out   status, count        one result per request
//
// The cells compare at the request transfer, then the cells from the target
// slot onward shift in parallel in the apply cycle.
// One request in flight; req.ready is high only while idle.
// A result waiting in the rsp register stalls the apply cycle.
// Reset (async, rst_n low) empties the set and drops any pending result.
module sorted_set_insert_delete_unit #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    ssid_in_if.sink     req,
    ssid_out_if.source  rsp
);
    import ssid_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    state_t                       state_reg;
    state_t                       state_next;
    op_t                          op_reg;
    logic signed [DATA_WIDTH-1:0] value_reg;
    logic signed [DATA_WIDTH-1:0] value_in;
    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             count_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    status_t                      status_reg;
    status_t                      status_next;
    logic [OUT_COUNT_W-1:0]       out_count_reg;

    logic                         accept;
    logic                         apply_go;
    logic                         found;
    logic                         full;
    cell_ctrl_t                   ctrl;

    logic signed [DATA_WIDTH-1:0] entry_vec [CAPACITY];
    cell_flags_t                  flag_vec  [CAPACITY];
    logic [CAPACITY-1:0]          eq_vec;

    assign value_in = DATA_WIDTH'(req.value);
    assign accept   = req.valid && req.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // FSM outputs
    always_comb
    begin
        req.ready = 1'b0;
        apply_go  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req.ready = 1'b1;
            end
            S_APPLY:
            begin
                apply_go = !out_valid_reg || rsp.ready;
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            eq_vec[i] = flag_vec[i].eq;
        end
    end

    assign found = |eq_vec;
    assign full  = (count_reg == CNT_W'(CAPACITY));

    always_comb
    begin
        ctrl.ins    = 1'b0;
        ctrl.del    = 1'b0;
        count_next  = count_reg;
        status_next = ST_ABSENT;
        case (op_reg)
            OP_INSERT:
            begin
                if (found)
                begin
                    status_next = ST_PRESENT;
                end
                else if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    status_next = ST_INSERTED;
                    ctrl.ins    = apply_go;
                    count_next  = count_reg + CNT_W'(1);
                end
            end
            OP_DELETE:
            begin
                if (found)
                begin
                    status_next = ST_DELETED;
                    ctrl.del    = apply_go;
                    count_next  = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
                status_next = ST_ABSENT;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (apply_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (apply_go)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= op_t'(req.operation);
            value_reg <= value_in;
        end
        if (apply_go)
        begin
            status_reg    <= status_next;
            out_count_reg <= OUT_COUNT_W'(count_next);
        end
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic signed [DATA_WIDTH-1:0] left_entry;
            logic                         left_ge;
            logic signed [DATA_WIDTH-1:0] right_entry;

            if (g == 0)
            begin : g_first
                assign left_entry = value_reg;
                assign left_ge    = 1'b0;
            end
            else
            begin : g_mid
                assign left_entry = entry_vec[g-1];
                assign left_ge    = flag_vec[g-1].ge;
            end

            if (g == CAPACITY - 1)
            begin : g_last
                assign right_entry = entry_vec[g];
            end
            else
            begin : g_inner
                assign right_entry = entry_vec[g+1];
            end

            ssid_cell #(
                .DATA_WIDTH (DATA_WIDTH),
                .CNT_W      (CNT_W),
                .INDEX      (g)
            ) u_cell (
                .clk         (clk),
                .cmp_en      (accept),
                .cmp_value   (value_in),
                .upd_value   (value_reg),
                .count       (count_reg),
                .ctrl        (ctrl),
                .left_entry  (left_entry),
                .left_ge     (left_ge),
                .right_entry (right_entry),
                .entry       (entry_vec[g]),
                .flags       (flag_vec[g])
            );
        end
    endgenerate

    assign rsp.valid  = out_valid_reg;
    assign rsp.status = status_reg;
    assign rsp.count  = out_count_reg;

endmodule
